FILE: hw/rtl/mbasc_pkg.sv
// ----------------------------------------------------------------------------
// mbasc_pkg
// Shared types, character codes and the hex digit decoder used by the ASCII
// request receiver.
// ----------------------------------------------------------------------------
package mbasc_pkg;

  localparam logic [7:0] CharColon = 8'd58;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharLf    = 8'd10;
  localparam logic [7:0] DigitBase = 8'd48;
  localparam logic [7:0] UpperBase = 8'd55;
  localparam logic [7:0] LowerBase = 8'd87;

  localparam int unsigned NumBytes     = 7;
  localparam int unsigned NumDataBytes = 6;

  localparam logic [2:0] LastIndex  = 3'(NumBytes);
  localparam logic [2:0] DataIndex  = 3'(NumDataBytes);
  localparam logic [7:0] FuncReadHr = 8'd3;

  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusFormat    = 3'd1,
    StatusLrc       = 3'd2,
    StatusNotAddr   = 3'd3,
    StatusIllegalFn = 3'd4,
    StatusIllegalQt = 3'd5
  } status_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  station_addr;
    logic [7:0]  function_code;
    logic [15:0] first_register;
    logic [15:0] register_count;
    logic        is_broadcast;
    status_e     status;
  } result_t;

  typedef struct packed {
    logic bad;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h = '{bad: 1'b1, value: 4'd0};
    d = 8'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      d = c - DigitBase;
      h = '{bad: 1'b0, value: d[3:0]};
    end else if (c >= 8'd65 && c <= 8'd70) begin
      d = c - UpperBase;
      h = '{bad: 1'b0, value: d[3:0]};
    end else if (c >= 8'd97 && c <= 8'd102) begin
      d = c - LowerBase;
      h = '{bad: 1'b0, value: d[3:0]};
    end
    return h;
  endfunction

endpackage

FILE: hw/rtl/mbasc_frame.sv
// ----------------------------------------------------------------------------
// mbasc_frame
// Frame tracker: decodes one character beat, updates the frame state and
// builds the request result when LF closes a frame.
// ----------------------------------------------------------------------------
module mbasc_frame #(
  parameter int unsigned MAX_READ_QUANTITY = 125
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          char_i,
  input  logic [7:0]          slave_address_i,
  output logic                lf_pending_o,
  output mbasc_pkg::result_t  result_o
);

  logic        in_frame_q, in_frame_d;
  logic [3:0]  pending_q, pending_d;
  logic        phase_q, phase_d;
  logic [2:0]  index_q, index_d;
  logic [7:0]  sum_q, sum_d;
  logic        fmt_bad_q, fmt_bad_d;
  logic        saw_cr_q, saw_cr_d;
  logic [7:0]  bytes_q [mbasc_pkg::NumDataBytes];

  mbasc_pkg::hex_t hex;
  logic [7:0]      new_byte;
  logic            byte_done;
  logic            is_colon, is_cr, is_lf;
  logic            fmt_fail;
  logic [15:0]     first_reg, count;

  assign hex      = mbasc_pkg::hex_decode(char_i);
  assign new_byte = {pending_q, hex.value};
  assign is_colon = (char_i == mbasc_pkg::CharColon);
  assign is_cr    = (char_i == mbasc_pkg::CharCr);
  assign is_lf    = (char_i == mbasc_pkg::CharLf);

  assign lf_pending_o = in_frame_q && is_lf;

  always_comb begin
    in_frame_d = in_frame_q;
    pending_d  = pending_q;
    phase_d    = phase_q;
    index_d    = index_q;
    sum_d      = sum_q;
    fmt_bad_d  = fmt_bad_q;
    saw_cr_d   = saw_cr_q;
    byte_done  = 1'b0;
    if (step_i) begin
      priority if (is_colon) begin
        in_frame_d = 1'b1;
        pending_d  = 4'd0;
        phase_d    = 1'b0;
        index_d    = 3'd0;
        sum_d      = 8'd0;
        fmt_bad_d  = 1'b0;
        saw_cr_d   = 1'b0;
      end else if (!in_frame_q) begin
        in_frame_d = 1'b0;
      end else if (is_cr) begin
        fmt_bad_d = fmt_bad_q | saw_cr_q;
        saw_cr_d  = 1'b1;
      end else if (is_lf) begin
        in_frame_d = 1'b0;
      end else if (hex.bad || saw_cr_q || index_q >= mbasc_pkg::LastIndex) begin
        fmt_bad_d = 1'b1;
      end else if (!phase_q) begin
        pending_d = hex.value;
        phase_d   = 1'b1;
      end else begin
        byte_done = 1'b1;
        sum_d     = sum_q + new_byte;
        index_d   = index_q + 3'd1;
        phase_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pending_q  <= 4'd0;
      phase_q    <= 1'b0;
      index_q    <= 3'd0;
      sum_q      <= 8'd0;
      fmt_bad_q  <= 1'b0;
      saw_cr_q   <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      pending_q  <= pending_d;
      phase_q    <= phase_d;
      index_q    <= index_d;
      sum_q      <= sum_d;
      fmt_bad_q  <= fmt_bad_d;
      saw_cr_q   <= saw_cr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_done && index_q < mbasc_pkg::DataIndex) begin
      bytes_q[index_q] <= new_byte;
    end
  end

  assign fmt_fail  = fmt_bad_q || !saw_cr_q || (index_q != mbasc_pkg::LastIndex) || phase_q;
  assign first_reg = {bytes_q[2], bytes_q[3]};
  assign count     = {bytes_q[4], bytes_q[5]};

  always_comb begin
    result_o       = '0;
    result_o.valid = step_i && lf_pending_o;
    if (fmt_fail) begin
      result_o.status = mbasc_pkg::StatusFormat;
    end else begin
      result_o.station_addr   = bytes_q[0];
      result_o.function_code  = bytes_q[1];
      result_o.first_register = first_reg;
      result_o.register_count = count;
      result_o.is_broadcast   = (bytes_q[0] == 8'd0);
      priority if (sum_q != 8'd0) begin
        result_o.status = mbasc_pkg::StatusLrc;
      end else if (bytes_q[0] != 8'd0 && bytes_q[0] != slave_address_i) begin
        result_o.status = mbasc_pkg::StatusNotAddr;
      end else if (bytes_q[1] != mbasc_pkg::FuncReadHr) begin
        result_o.status = mbasc_pkg::StatusIllegalFn;
      end else if (count < 16'd1 || count > 16'(MAX_READ_QUANTITY)) begin
        result_o.status = mbasc_pkg::StatusIllegalQt;
      end else begin
        result_o.status = mbasc_pkg::StatusOk;
      end
    end
  end

  a_phase_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> index_q < mbasc_pkg::LastIndex)
    else $error("half byte pending with all bytes already complete");

endmodule

FILE: hw/rtl/mbasc_result_reg.sv
// ----------------------------------------------------------------------------
// mbasc_result_reg
// Output register for request results; holds a beat while the sink stalls.
// ----------------------------------------------------------------------------
module mbasc_result_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbasc_pkg::result_t  result_i,
  input  logic                out_stall_i,
  output logic                free_o,
  output logic                out_valid_o,
  output mbasc_pkg::result_t  result_o
);

  logic               valid_q, valid_d;
  mbasc_pkg::result_t data_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (result_i.valid) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

FILE: hw/rtl/modbus_ascii_request_receiver_core.sv
// ----------------------------------------------------------------------------
// modbus_ascii_request_receiver_core
// Receives ASCII request frames one character per beat and returns one
// decoded request with status for every frame closed by LF.
// An accepted LF beat passes the input register, then the result register.
// Throughput: one character per cycle; the input stalls only while an LF beat
// waits behind a result that the sink is stalling.
// Reset: asynchronous, active low; clears frame state, empties both register
// stages and sets the station address to 1.
// ----------------------------------------------------------------------------
module modbus_ascii_request_receiver_core #(
  parameter int unsigned MAX_READ_QUANTITY = 125
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  station_addr_o,
  output logic [7:0]  function_code_o,
  output logic [15:0] first_register_o,
  output logic [15:0] register_count_o,
  output logic        is_broadcast_o,
  output logic [2:0]  status_o
);

  logic       cfg_write;
  logic [7:0] slave_address_q;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_char_q;
  logic       in_accept, advance, out_free, lf_pending;

  mbasc_pkg::result_t frame_res, out_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q <= 8'd1;
    end else if (cfg_write) begin
      slave_address_q <= cfg_wdata_i;
    end
  end

  assign advance    = !lf_pending || out_free;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_char_q <= rx_char_i;
    end
  end

  mbasc_frame #(
    .MAX_READ_QUANTITY (MAX_READ_QUANTITY)
  ) u_frame (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (in_valid_q && advance),
    .char_i          (in_char_q),
    .slave_address_i (slave_address_q),
    .lf_pending_o    (lf_pending),
    .result_o        (frame_res)
  );

  mbasc_result_reg u_result_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (frame_res),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .result_o    (out_res)
  );

  assign station_addr_o   = out_res.station_addr;
  assign function_code_o  = out_res.function_code;
  assign first_register_o = out_res.first_register;
  assign register_count_o = out_res.register_count;
  assign is_broadcast_o   = out_res.is_broadcast;
  assign status_o         = out_res.status;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_o)
    else $error("input stalled without a held character and result");

  a_format_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mbasc_pkg::StatusFormat |->
      station_addr_o == 8'd0 && function_code_o == 8'd0 &&
      first_register_o == 16'd0 && register_count_o == 16'd0 && !is_broadcast_o)
    else $error("format failure with nonzero fields");

  a_broadcast_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_broadcast_o |-> station_addr_o == 8'd0)
    else $error("broadcast flag with nonzero address");

endmodule
